@@ hw/rtl/rld_pkg.sv @@
// Package for the run list decoder: phase codes, field widths and limits.
`timescale 1ns / 1ps

package rld_pkg;

  localparam int unsigned MaxFieldBytes = 8;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SizeW    = 4;
  localparam int unsigned AccW     = 64;
  localparam int unsigned ClusterW = 63;

  localparam int unsigned PhaseW = 2;
  localparam logic [PhaseW-1:0] PH_HEADER = 2'd0;
  localparam logic [PhaseW-1:0] PH_LENGTH = 2'd1;
  localparam logic [PhaseW-1:0] PH_OFFSET = 2'd2;

endpackage

@@ hw/rtl/runlist_decoder.sv @@
// Top level of the run list decoder: mapping-pair bytes in, one run per pair out.
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// -------   ---  ---------               -------
// in        in   in_valid_i / in_stall_o  run_byte_i, list_start_i
// out       out  out_valid_o / out_stall_i
//                                         start_cluster_o, run_clusters_o, sparse_run_o,
//                                         list_end_o, format_error_o
//
// One byte per cycle sustained unless results back up. A byte is decoded
// in the input register; its result, if any, goes to the result register as
// the byte leaves. The result register frees in the cycle it is taken, so a
// stalled result only holds up a byte that would produce another result.
// Reset clears the decode state and both valid flags; list_start_i does the
// same for the running state ahead of its own byte.
module runlist_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rld_pkg::ByteW-1:0]         run_byte_i,
  input  logic                              list_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rld_pkg::ClusterW-1:0]      start_cluster_o,
  output logic [rld_pkg::AccW-1:0]          run_clusters_o,
  output logic                              sparse_run_o,
  output logic                              list_end_o,
  output logic                              format_error_o
);

  // input register
  logic                        in_vld_q;
  logic [rld_pkg::ByteW-1:0]   in_byte_q;
  logic                        in_start_q;

  // decode state
  logic [rld_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [rld_pkg::SizeW-1:0]   bytes_left_q, bytes_left_d;
  logic [rld_pkg::SizeW-1:0]   offset_size_q, offset_size_d;
  logic [rld_pkg::SizeW-1:0]   byte_index_q, byte_index_d;
  logic [rld_pkg::AccW-1:0]    length_acc_q, length_acc_d;
  logic [rld_pkg::AccW-1:0]    offset_acc_q, offset_acc_d;
  logic [rld_pkg::AccW-1:0]    cur_cluster_q, cur_cluster_d;

  // result register
  logic                          out_vld_q;
  logic [rld_pkg::ClusterW-1:0]  start_cluster_q, start_cluster_d;
  logic [rld_pkg::AccW-1:0]      run_clusters_q, run_clusters_d;
  logic                          sparse_q, sparse_d;
  logic                          end_q, end_d;
  logic                          err_q, err_d;

  logic has_result;
  logic out_free;
  logic step;

  // state as seen by the byte in the input register (list start clears it)
  logic [rld_pkg::PhaseW-1:0]  ph;
  logic [rld_pkg::SizeW-1:0]   left_c, osz_c, idx_c;
  logic [rld_pkg::AccW-1:0]    len_c, off_c, cur_c;

  logic [rld_pkg::SizeW-1:0]   hdr_lsz, hdr_osz;
  logic [rld_pkg::AccW-1:0]    lane;
  logic [rld_pkg::SizeW-1:0]   left_dec;
  logic [rld_pkg::AccW-1:0]    len_new, off_new, off_ext, sum;
  logic [2:0]                  top_byte;
  logic                        sign;
  logic                        finish;

  always_comb begin
    ph     = in_start_q ? rld_pkg::PH_HEADER : phase_q;
    left_c = in_start_q ? '0 : bytes_left_q;
    osz_c  = in_start_q ? '0 : offset_size_q;
    idx_c  = in_start_q ? '0 : byte_index_q;
    len_c  = in_start_q ? '0 : length_acc_q;
    off_c  = in_start_q ? '0 : offset_acc_q;
    cur_c  = in_start_q ? '0 : cur_cluster_q;

    hdr_lsz  = in_byte_q[3:0];
    hdr_osz  = in_byte_q[7:4];
    lane     = rld_pkg::AccW'(in_byte_q) << {idx_c[2:0], 3'b000};
    left_dec = (left_c != '0) ? left_c - 4'd1 : left_c;
    len_new  = len_c | lane;
    off_new  = off_c | lane;

    // sign-extend the offset from bit 7 of its top byte, then add
    top_byte = 3'(osz_c - 4'd1);
    sign     = off_new[{top_byte, 3'b111}];
    off_ext  = off_new;
    if (sign) begin
      off_ext = off_new | ({rld_pkg::AccW{1'b1}} << {osz_c, 3'b000});
    end
    sum = cur_c + off_ext;

    phase_d       = ph;
    bytes_left_d  = left_c;
    offset_size_d = osz_c;
    byte_index_d  = idx_c;
    length_acc_d  = len_c;
    offset_acc_d  = off_c;
    cur_cluster_d = cur_c;

    has_result      = 1'b0;
    start_cluster_d = '0;
    run_clusters_d  = '0;
    sparse_d        = 1'b0;
    end_d           = 1'b0;
    err_d           = 1'b0;
    finish          = 1'b0;

    unique case (ph)
      rld_pkg::PH_HEADER: begin
        if (in_byte_q == '0) begin
          cur_cluster_d = '0;
          has_result    = 1'b1;
          end_d         = 1'b1;
        end else if (hdr_lsz > rld_pkg::SizeW'(rld_pkg::MaxFieldBytes) ||
                     hdr_osz > rld_pkg::SizeW'(rld_pkg::MaxFieldBytes)) begin
          has_result = 1'b1;
          err_d      = 1'b1;
        end else begin
          offset_size_d = hdr_osz;
          length_acc_d  = '0;
          offset_acc_d  = '0;
          byte_index_d  = '0;
          if (hdr_lsz != '0) begin
            phase_d      = rld_pkg::PH_LENGTH;
            bytes_left_d = hdr_lsz;
          end else begin
            phase_d      = rld_pkg::PH_OFFSET;
            bytes_left_d = hdr_osz;
          end
        end
      end
      rld_pkg::PH_LENGTH: begin
        length_acc_d = len_new;
        byte_index_d = idx_c + 4'd1;
        bytes_left_d = left_dec;
        if (left_dec == '0) begin
          if (osz_c == '0) begin
            // sparse run: no offset bytes follow
            phase_d        = rld_pkg::PH_HEADER;
            has_result     = 1'b1;
            run_clusters_d = len_new;
            sparse_d       = 1'b1;
          end else begin
            phase_d      = rld_pkg::PH_OFFSET;
            bytes_left_d = osz_c;
            byte_index_d = '0;
          end
        end
      end
      rld_pkg::PH_OFFSET: begin
        offset_acc_d = off_new;
        byte_index_d = idx_c + 4'd1;
        bytes_left_d = left_dec;
        finish       = (left_dec == '0);
      end
      default: begin
        phase_d = rld_pkg::PH_HEADER;
      end
    endcase

    if (finish) begin
      phase_d        = rld_pkg::PH_HEADER;
      has_result     = 1'b1;
      run_clusters_d = len_c;
      if (sum[rld_pkg::AccW-1]) begin
        err_d = 1'b1;               // negative start cluster, keep running value
      end else begin
        cur_cluster_d   = sum;
        start_cluster_d = sum[rld_pkg::ClusterW-1:0];
      end
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && (!has_result || out_free);
  assign in_stall_o = in_vld_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= run_byte_i;
      in_start_q <= list_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= rld_pkg::PH_HEADER;
      bytes_left_q  <= '0;
      offset_size_q <= '0;
      byte_index_q  <= '0;
      length_acc_q  <= '0;
      offset_acc_q  <= '0;
      cur_cluster_q <= '0;
    end else if (step) begin
      phase_q       <= phase_d;
      bytes_left_q  <= bytes_left_d;
      offset_size_q <= offset_size_d;
      byte_index_q  <= byte_index_d;
      length_acc_q  <= length_acc_d;
      offset_acc_q  <= offset_acc_d;
      cur_cluster_q <= cur_cluster_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && has_result) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_result) begin
      start_cluster_q <= start_cluster_d;
      run_clusters_q  <= run_clusters_d;
      sparse_q        <= sparse_d;
      end_q           <= end_d;
      err_q           <= err_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign start_cluster_o = start_cluster_q;
  assign run_clusters_o  = run_clusters_q;
  assign sparse_run_o    = sparse_q;
  assign list_end_o      = end_q;
  assign format_error_o  = err_q;

endmodule

@@ tb/rld_checker.sv @@
// Run list decoder checker: predicts each run from accepted bytes and compares results.
`timescale 1ns / 1ps

module rld_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [rld_pkg::ByteW-1:0]     run_byte_i,
  input  logic                          list_start_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [rld_pkg::ClusterW-1:0]  start_cluster_i,
  input  logic [rld_pkg::AccW-1:0]      run_clusters_i,
  input  logic                          sparse_run_i,
  input  logic                          list_end_i,
  input  logic                          format_error_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import rld_pkg::*;

  typedef struct packed {
    logic [ClusterW-1:0] start_cl;
    logic [AccW-1:0]     clusters;
    logic                sparse;
    logic                list_end;
    logic                err;
  } run_rec_t;

  // shadow decode state
  logic [PhaseW-1:0] phase_q;
  logic [SizeW-1:0]  left_q;
  logic [SizeW-1:0]  osz_q;
  logic [SizeW-1:0]  idx_q;
  logic [AccW-1:0]   len_acc;
  logic [AccW-1:0]   off_acc;
  logic [AccW-1:0]   cur_cluster;

  run_rec_t runs_due[$];

  function automatic void clear_state();
    phase_q     = PH_HEADER;
    left_q      = '0;
    osz_q       = '0;
    idx_q       = '0;
    len_acc     = '0;
    off_acc     = '0;
    cur_cluster = '0;
  endfunction

  // pair done: unless sparse, sign-extend offset and move running cluster if not negative
  function automatic void close_pair(output run_rec_t r);
    logic [AccW-1:0] off;
    logic [AccW-1:0] nxt;
    phase_q    = PH_HEADER;
    r          = '0;
    r.clusters = len_acc;
    if (osz_q == 0) begin
      r.sparse = 1'b1;
      return;
    end
    off = off_acc;
    if (osz_q < MaxFieldBytes && off[8*int'(osz_q)-1])
      off |= {AccW{1'b1}} << (8 * int'(osz_q));
    nxt = cur_cluster + off;
    if (nxt[AccW-1]) begin
      r.err = 1'b1;
    end else begin
      cur_cluster = nxt;
      r.start_cl  = nxt[ClusterW-1:0];
    end
  endfunction

  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic first,
                                     output run_rec_t r);
    logic [SizeW-1:0] lsz;
    logic [SizeW-1:0] osz;
    r = '0;
    if (first) clear_state();
    case (phase_q)
      PH_HEADER: begin
        if (b == '0) begin
          cur_cluster = '0;
          r.list_end  = 1'b1;
          return 1'b1;
        end
        lsz = b[3:0];
        osz = b[7:4];
        if (lsz > MaxFieldBytes || osz > MaxFieldBytes) begin
          r.err = 1'b1;
          return 1'b1;
        end
        osz_q   = osz;
        len_acc = '0;
        off_acc = '0;
        idx_q   = '0;
        if (lsz != 0) begin
          phase_q = PH_LENGTH;
          left_q  = lsz;
        end else begin
          phase_q = PH_OFFSET;
          left_q  = osz;
        end
        return 1'b0;
      end
      PH_LENGTH: begin
        len_acc |= AccW'(b) << (8 * int'(idx_q[2:0]));
        idx_q++;
        if (left_q > 0) left_q--;
        if (left_q == 0) begin
          if (osz_q == 0) begin
            close_pair(r);
            return 1'b1;
          end
          phase_q = PH_OFFSET;
          left_q  = osz_q;
          idx_q   = '0;
        end
        return 1'b0;
      end
      PH_OFFSET: begin
        off_acc |= AccW'(b) << (8 * int'(idx_q[2:0]));
        idx_q++;
        if (left_q > 0) left_q--;
        if (left_q == 0) begin
          close_pair(r);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        phase_q = PH_HEADER;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [AccW-1:0] want,
                                      input logic [AccW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    run_rec_t want;
    run_rec_t r;
    if (!rst_ni) begin
      clear_state();
      runs_due.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (runs_due.size() == 0) begin
          $error("run result with nothing due");
          fail_count_o++;
        end else begin
          want = runs_due.pop_front();
          check_field("start_cluster", AccW'(want.start_cl), AccW'(start_cluster_i));
          check_field("run_clusters", want.clusters, run_clusters_i);
          check_field("sparse_run", AccW'(want.sparse), AccW'(sparse_run_i));
          check_field("list_end", AccW'(want.list_end), AccW'(list_end_i));
          check_field("format_error", AccW'(want.err), AccW'(format_error_i));
        end
      end
      if (in_valid_i && !in_stall_i && decode_byte(run_byte_i, list_start_i, r))
        runs_due.push_back(r);
      pending_o = runs_due.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the run list decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rld_pkg::*;

  // longest quiet spell tolerated; the deliberate hold-off is well inside it
  localparam int StallLimit  = 3000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;
  localparam int PhaseItems  = 200;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic [ByteW-1:0]    run_byte   = '0;
  logic                list_start = 1'b0;
  logic                out_stall  = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [ClusterW-1:0] start_cluster;
  logic [AccW-1:0]     run_clusters;
  logic                sparse_run;
  logic                list_end;
  logic                format_error;
  int unsigned         fails;
  int unsigned         pending;

  // idling controls, changed between phases by the stimulus, and progress counters
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_done    = 0;
  int bytes_sent   = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  runlist_decoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .run_byte_i     (run_byte),
    .list_start_i   (list_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .start_cluster_o(start_cluster),
    .run_clusters_o (run_clusters),
    .sparse_run_o   (sparse_run),
    .list_end_o     (list_end),
    .format_error_o (format_error)
  );

  rld_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .run_byte_i     (run_byte),
    .list_start_i   (list_start),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .start_cluster_i(start_cluster),
    .run_clusters_i (run_clusters),
    .sparse_run_i   (sparse_run),
    .list_end_i     (list_end),
    .format_error_i (format_error),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  // Result side. A hold-off request freezes the receiver for a long, counted
  // stretch so that the result register fills and the decoder back-pressures
  // its byte input; otherwise stall is drawn afresh every cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done = hold_done + 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: any cycle without a transaction on either channel counts
  // towards the limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // One byte transaction. Idle gaps come first, so valid only drops when a gap
  // is actually taken; the payload then holds until the byte is accepted.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic first);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    run_byte   <= b;
    list_start <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Field sizes: mostly narrow, a quarter of the time anywhere up to eight bytes.
  function automatic int draw_size();
    return ($urandom_range(3) == 0) ? $urandom_range(MaxFieldBytes) : $urandom_range(2);
  endfunction

  // A mapping-pair list with random content. Broken lists are cut short at a
  // random byte, leaving the decoder part way through until a marked list start.
  task automatic send_list(input bit broken);
    logic [ByteW-1:0] bytes[$];
    logic [ByteW-1:0] v;
    int               pairs;
    int               lsz;
    int               osz;
    bit               mark;
    pairs = $urandom_range(1, 6);
    mark  = ($urandom_range(3) != 0);
    repeat (pairs) begin
      lsz = draw_size();
      osz = draw_size();
      if (lsz == 0 && osz == 0) lsz = 1;
      bytes.push_back({osz[3:0], lsz[3:0]});
      repeat (lsz) bytes.push_back(ByteW'($urandom_range(255)));
      for (int i = 0; i < osz; i++) begin
        v = ByteW'($urandom_range(255));
        // lean towards forward jumps so the running cluster can grow large
        if (i == osz - 1 && $urandom_range(3) != 0) v[7] = 1'b0;
        bytes.push_back(v);
      end
    end
    if (broken) repeat ($urandom_range(bytes.size() - 1)) void'(bytes.pop_back());
    else bytes.push_back(8'h00);
    foreach (bytes[i]) send_byte(bytes[i], mark && i == 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: end marker, forward and backward jumps, a negative start,
    // sparse run, zero-length field, oversized sizes, eight-byte length.
    send_byte(8'h00, 1'b1);
    send_byte(8'h11, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h11, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h05, 1'b0);
    send_byte(8'h10, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h18, 1'b0); send_byte(8'h02, 1'b0);
    repeat (MaxFieldBytes) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    // Random phases: hold-off only, sender idle, receiver stalling, then both.
    for (int m = 0; m < 4; m++) begin
      tx_idle_pct  = (m == 1) ? 81 : (m == 3) ? 23 : 0;
      rx_stall_pct = (m == 2) ? 81 : (m == 3) ? 23 : 0;
      if (m == 0) hold_req = hold_req + 1;
      while (bytes_sent < (m + 1) * PhaseItems) begin
        case ($urandom_range(9))
          7, 8: send_list(1'b1);
          9: repeat ($urandom_range(1, 4))
               send_byte(ByteW'($urandom_range(255)), $urandom_range(3) == 0);
          default: send_list(1'b0);
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a result still in the pipe with nothing due would show up here
    repeat (DrainCycles) @(posedge clk);

    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
